@@ hdl/disk_to_square_grid_mapping_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Disk-to-square mapping unit: assertion macros
// Shared concurrent assertion forms, clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef DISK_TO_SQUARE_GRID_MAPPING_UNIT_MACROS_SVH
`define DISK_TO_SQUARE_GRID_MAPPING_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define D2SQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset
`define D2SQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/d2sq_pkg.sv @@
// ----------------------------------------------------------------------------
// d2sq_pkg
// Shared types, constants and the arctangent table of the disk-to-square unit.
// ----------------------------------------------------------------------------
package d2sq_pkg;

    // Default configuration
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    // Fixed-point formats
    localparam int GUARD_BITS = 8;     // extra fraction bits inside the CORDIC
    localparam int ANGLE_FRAC = 16;    // angle unit: pi/4 = 2^ANGLE_FRAC
    localparam int ZW         = ANGLE_FRAC + 3;  // signed angle accumulator
    localparam int ATAN_W     = ANGLE_FRAC + 1;  // table entry width
    localparam int GAIN_W     = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int SPLIT_BITS = 24;    // low slice width of the split multipliers

    // Quadrant regions, each 90 degrees wide, starting at -pi/4
    typedef enum logic [1:0] {
        REGION_ONE   = 2'd0,
        REGION_TWO   = 2'd1,
        REGION_THREE = 2'd2,
        REGION_FOUR  = 2'd3
    } region_t;

    // Control that travels with each request through the pipeline
    typedef struct packed {
        logic    valid;
        region_t region;
    } ctl_t;

    // round(atan(2^-i) * (4/pi) * 2^16)
    function automatic logic [ATAN_W-1:0] atan_units(input int unsigned idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            0:       val = 17'd65536;
            1:       val = 17'd38688;
            2:       val = 17'd20442;
            3:       val = 17'd10377;
            4:       val = 17'd5208;
            5:       val = 17'd2607;
            6:       val = 17'd1304;
            7:       val = 17'd652;
            8:       val = 17'd326;
            9:       val = 17'd163;
            10:      val = 17'd81;
            11:      val = 17'd41;
            12:      val = 17'd20;
            13:      val = 17'd10;
            14:      val = 17'd5;
            15:      val = 17'd3;
            16:      val = 17'd1;
            17:      val = 17'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ hdl/d2sq_prerot.sv @@
// ----------------------------------------------------------------------------
// d2sq_prerot
// Picks the quadrant region of a point and turns it by a multiple of
// 90 degrees into region one, scaled up by the guard bits.
// ----------------------------------------------------------------------------
module d2sq_prerot #(
    parameter int W  = 16,
    parameter int CW = 27
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output d2sq_pkg::ctl_t       ctl_out,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out
);
    import d2sq_pkg::*;

    localparam int EW = W + 1;

    logic signed [EW-1:0] xe, ye, nxe, nye, px, py;
    region_t              region;
    ctl_t                 ctl_reg, ctl_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;

    // Classify the point and rotate it into region one
    always_comb begin
        xe  = EW'(x_in);
        ye  = EW'(y_in);
        nxe = -xe;
        nye = -ye;
        if (((xe == '0) && (ye == '0)) || ((xe > 0) && (ye >= nxe) && (ye < xe))) begin
            region = REGION_ONE;
            px     = xe;
            py     = ye;
        end else if ((ye > 0) && (xe <= ye) && (xe > nye)) begin
            region = REGION_TWO;
            px     = ye;
            py     = nxe;
        end else if ((xe < 0) && (ye <= nxe) && (ye > xe)) begin
            region = REGION_THREE;
            px     = nxe;
            py     = nye;
        end else begin
            region = REGION_FOUR;
            px     = nye;
            py     = xe;
        end
        ctl_next.valid  = in_valid;
        ctl_next.region = region;
        x_next = {{(CW-EW-GUARD_BITS){px[EW-1]}}, px, {GUARD_BITS{1'b0}}};
        y_next = {{(CW-EW-GUARD_BITS){py[EW-1]}}, py, {GUARD_BITS{1'b0}}};
    end

    // Hold while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_next.valid;
        end
        if (en) begin
            ctl_reg.region <= ctl_next.region;
            x_reg          <= x_next;
            y_reg          <= y_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

@@ hdl/d2sq_cell.sv @@
// ----------------------------------------------------------------------------
// d2sq_cell
// One vectoring CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module d2sq_cell #(
    parameter int CW    = 27,
    parameter int SHIFT = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  d2sq_pkg::ctl_t               ctl_in,
    input  logic signed [CW-1:0]         x_in,
    input  logic signed [CW-1:0]         y_in,
    input  logic signed [d2sq_pkg::ZW-1:0] z_in,
    output d2sq_pkg::ctl_t               ctl_out,
    output logic signed [CW-1:0]         x_out,
    output logic signed [CW-1:0]         y_out,
    output logic signed [d2sq_pkg::ZW-1:0] z_out
);
    import d2sq_pkg::*;

    localparam logic signed [ZW-1:0] ZSTEP = ZW'(atan_units(SHIFT));

    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    ctl_t                 ctl_reg;

    // Rotate toward the x axis; shifts round toward minus infinity
    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!y_in[CW-1]) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ZSTEP;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ZSTEP;
        end
    end

    // Advance one stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
        if (en) begin
            ctl_reg.region <= ctl_in.region;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

@@ hdl/d2sq_post.sv @@
// ----------------------------------------------------------------------------
// d2sq_post
// Removes the CORDIC gain, scales the residual angle by the radius, maps
// the region back to square coordinates and clamps to [0, 1].
// ----------------------------------------------------------------------------
module d2sq_post #(
    parameter int W  = 16,
    parameter int CW = 27
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  d2sq_pkg::ctl_t                 ctl_in,
    input  logic signed [CW-1:0]           x_in,
    input  logic signed [d2sq_pkg::ZW-1:0] z_in,
    output logic                           out_valid,
    output logic [W-1:0]                   grid_u,
    output logic [W-1:0]                   grid_v,
    output logic                           clamped
);
    import d2sq_pkg::*;

    localparam int RW   = CW - 1;
    localparam int UXW  = (RW > SPLIT_BITS) ? RW : SPLIT_BITS + 1;
    localparam int HIW  = UXW - SPLIT_BITS;
    localparam int PLW  = SPLIT_BITS + GAIN_W;
    localparam int PHW  = HIW + GAIN_W;
    localparam int SMW  = UXW + GAIN_W;
    localparam int QLW  = SPLIT_BITS + 1 + ZW;
    localparam int QHW  = HIW + 1 + ZW;
    localparam int PW   = QHW + SPLIT_BITS + 1;
    localparam int OW   = CW + 1;
    localparam logic signed [PW-1:0] RND  = PW'(1) <<< (ANGLE_FRAC - 1);
    localparam logic signed [OW-1:0] ONE  = OW'(1) <<< (W - 1 + GUARD_BITS);
    localparam logic signed [OW-1:0] HALF = OW'(1) <<< GUARD_BITS;
    localparam logic signed [OW-1:0] TOP  = OW'(1) <<< (W - 1);

    // Stage one: split gain products
    logic [UXW-1:0]       ux;
    logic [PLW-1:0]       pl_reg, pl_next;
    logic [PHW-1:0]       ph_reg, ph_next;
    logic signed [ZW-1:0] z1_reg;
    ctl_t                 ctl1_reg;
    // Stage two: radius
    logic [SMW-1:0]       gsum;
    logic [RW-1:0]        r2_reg, r2_next;
    logic signed [ZW-1:0] z2_reg;
    ctl_t                 ctl2_reg;
    // Stage three: split radius-angle products
    logic [UXW-1:0]       rx;
    logic signed [QLW-1:0] ql_reg, ql_next;
    logic signed [QHW-1:0] qh_reg, qh_next;
    logic [RW-1:0]        r3_reg;
    ctl_t                 ctl3_reg;
    // Stage four: scaled angle
    logic signed [PW-1:0] tsum;
    logic signed [CW-1:0] s4_reg, s4_next;
    logic [RW-1:0]        r4_reg;
    ctl_t                 ctl4_reg;
    // Stage five: output register
    logic signed [CW-1:0] rs, ca, cb;
    logic [W-1:0]         u_reg, u_next, v_reg, v_next;
    logic                 hit_reg, hit_next, valid_reg;
    logic [W:0]           ures, vres;

    // Map one signed coordinate to [0, 1], flag in the top bit
    function automatic logic [W:0] to_unit(input logic signed [CW-1:0] c);
        logic signed [OW-1:0] q;
        logic [W:0]           res;
        q = (OW'(c) + ONE + HALF) >>> (GUARD_BITS + 1);
        if (q[OW-1]) begin
            res = {1'b1, {W{1'b0}}};
        end else if (q > TOP) begin
            res = {1'b1, W'(TOP)};
        end else begin
            res = {1'b0, W'(q)};
        end
        return res;
    endfunction

    always_comb begin
        // Stage one
        ux      = (!x_in[CW-1] && (x_in != '0)) ? UXW'(x_in[CW-2:0]) : '0;
        pl_next = PLW'(ux[SPLIT_BITS-1:0]) * PLW'(INV_GAIN_Q30);
        ph_next = PHW'(ux[UXW-1:SPLIT_BITS]) * PHW'(INV_GAIN_Q30);
        // Stage two
        gsum    = SMW'({ph_reg, {SPLIT_BITS{1'b0}}}) + SMW'(pl_reg);
        r2_next = RW'(gsum[SMW-1:GAIN_W]);
        // Stage three
        rx      = UXW'(r2_reg);
        ql_next = QLW'(signed'({1'b0, rx[SPLIT_BITS-1:0]})) * QLW'(z2_reg);
        qh_next = QHW'(signed'({1'b0, rx[UXW-1:SPLIT_BITS]})) * QHW'(z2_reg);
        // Stage four
        tsum    = PW'(signed'({qh_reg, {SPLIT_BITS{1'b0}}})) + PW'(ql_reg) + RND;
        s4_next = CW'(tsum >>> ANGLE_FRAC);
        // Stage five: map region back and clamp
        rs = signed'(CW'(r4_reg));
        case (ctl4_reg.region)
            REGION_ONE: begin
                ca = rs;
                cb = s4_reg;
            end
            REGION_TWO: begin
                ca = -s4_reg;
                cb = rs;
            end
            REGION_THREE: begin
                ca = -rs;
                cb = -s4_reg;
            end
            default: begin
                ca = s4_reg;
                cb = -rs;
            end
        endcase
        ures     = to_unit(ca);
        vres     = to_unit(cb);
        u_next   = ures[W-1:0];
        v_next   = vres[W-1:0];
        hit_next = ures[W] | vres[W];
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
            ctl4_reg.valid <= 1'b0;
            valid_reg      <= 1'b0;
        end else if (en) begin
            ctl1_reg.valid <= ctl_in.valid;
            ctl2_reg.valid <= ctl1_reg.valid;
            ctl3_reg.valid <= ctl2_reg.valid;
            ctl4_reg.valid <= ctl3_reg.valid;
            valid_reg      <= ctl4_reg.valid;
        end
        if (en) begin
            ctl1_reg.region <= ctl_in.region;
            pl_reg          <= pl_next;
            ph_reg          <= ph_next;
            z1_reg          <= z_in;
            ctl2_reg.region <= ctl1_reg.region;
            r2_reg          <= r2_next;
            z2_reg          <= z1_reg;
            ctl3_reg.region <= ctl2_reg.region;
            ql_reg          <= ql_next;
            qh_reg          <= qh_next;
            r3_reg          <= r2_reg;
            ctl4_reg.region <= ctl3_reg.region;
            s4_reg          <= s4_next;
            r4_reg          <= r3_reg;
            u_reg           <= u_next;
            v_reg           <= v_next;
            hit_reg         <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign grid_u    = u_reg;
    assign grid_v    = v_reg;
    assign clamped   = hit_reg;

endmodule

@@ hdl/disk_to_square_grid_mapping_unit.sv @@
// ----------------------------------------------------------------------------
// disk_to_square_grid_mapping_unit
// Inverse concentric map of a point on the unit disk to the unit square.
// ----------------------------------------------------------------------------
// Takes one point per cycle and returns one result per point, in order.
// The pipeline is one pre-rotation stage, one pipelined CORDIC
// cell per iteration, four stages of gain and angle scaling, and
// the output register. Throughput is one point per clock; the
// whole pipeline holds while a finished result is not
// taken. s_axis_tdata carries disk_x in the low half and disk_y above it;
// m_axis_tdata carries grid_u low and grid_v above it; m_axis_tuser is the
// clamp flag, set when the point lies outside the disk.
`include "disk_to_square_grid_mapping_unit_macros.svh"

module disk_to_square_grid_mapping_unit #(
    parameter int COORD_WIDTH      = d2sq_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_ITERATIONS = d2sq_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // disk_x, disk_y (low to high), zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // grid_u, grid_v (low to high), zero padded to bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // clamped
    output logic                                 m_axis_tuser
);
    import d2sq_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int N      = ANGLE_ITERATIONS;
    localparam int CW     = W + GUARD_BITS + 3;
    localparam int DATA_W = ((2*W+7)/8)*8;
    localparam logic [W-1:0] TOP = W'(1) << (W - 1);

    logic                 en;
    logic signed [W-1:0]  disk_x, disk_y;
    ctl_t                 ctl_chain [0:N];
    logic signed [CW-1:0] x_chain [0:N];
    logic signed [CW-1:0] y_chain [0:N];
    logic signed [ZW-1:0] z_chain [0:N];
    logic                 out_valid, clamped;
    logic [W-1:0]         grid_u, grid_v;

    // Advance whenever the output register is free or being drained
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign disk_x = signed'(s_axis_tdata[W-1:0]);
    assign disk_y = signed'(s_axis_tdata[2*W-1:W]);

    // Pre-rotate into region one
    d2sq_prerot #(
        .W  (W),
        .CW (CW)
    ) u_prerot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .x_in     (disk_x),
        .y_in     (disk_y),
        .ctl_out  (ctl_chain[0]),
        .x_out    (x_chain[0]),
        .y_out    (y_chain[0])
    );

    assign z_chain[0] = '0;

    // Chain of CORDIC cells, one micro-rotation each
    for (genvar i = 0; i < N; i++) begin : g_cell
        d2sq_cell #(
            .CW    (CW),
            .SHIFT (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_chain[i]),
            .x_in    (x_chain[i]),
            .y_in    (y_chain[i]),
            .z_in    (z_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .x_out   (x_chain[i+1]),
            .y_out   (y_chain[i+1]),
            .z_out   (z_chain[i+1])
        );
    end

    // Gain removal, angle scaling, region map and clamp
    d2sq_post #(
        .W  (W),
        .CW (CW)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_chain[N]),
        .x_in      (x_chain[N]),
        .z_in      (z_chain[N]),
        .out_valid (out_valid),
        .grid_u    (grid_u),
        .grid_v    (grid_v),
        .clamped   (clamped)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = DATA_W'({grid_v, grid_u});
    assign m_axis_tuser  = clamped;

    // A result waiting at the output must stall intake
    `D2SQ_ASSERT_IMP(a_stall_blocks_intake, out_valid && !m_axis_tready, !s_axis_tready, "intake open while result stalled")
    // Results never exceed one
    `D2SQ_ASSERT_IMP(a_result_in_range, out_valid, (grid_u <= TOP) && (grid_v <= TOP), "result above one")
    // Reset empties the output register
    `D2SQ_ASSERT_NXT(a_reset_clears, !aresetn, !m_axis_tvalid, "result valid after reset")

endmodule
